// ----- hdl/imu_spike_reject_and_scale_unit_assert.svh -----
// ---------------------------------------------------------------------------
// IMU spike reject and scale unit: assertion macros
// Concurrent assertion wrappers sampled on clk; IMUSR_ASSERT is disabled in reset rst_n (active low).
// ---------------------------------------------------------------------------
`ifndef IMU_SPIKE_REJECT_AND_SCALE_UNIT_ASSERT_SVH
`define IMU_SPIKE_REJECT_AND_SCALE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define IMUSR_ASSERT(lbl, prp, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prp) else $error(msg);

`define IMUSR_ASSERT_ALWAYS(lbl, prp, msg) \
  lbl: assert property (@(posedge clk) prp) else $error(msg);

`else

`define IMUSR_ASSERT(lbl, prp, msg)

`define IMUSR_ASSERT_ALWAYS(lbl, prp, msg)

`endif

`endif

// ----- hdl/imusr_pkg.sv -----
// ---------------------------------------------------------------------------
// IMU spike reject and scale package
// Field widths, register codes, reset values and scaling constants.
// ---------------------------------------------------------------------------
package imusr_pkg;

  localparam int RAW_W   = 16;
  localparam int ACC_W   = 15;
  localparam int GYR_W   = 16;
  localparam int TMP_W   = 17;
  localparam int AXES    = 6;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic REG_ACC_LIMIT = 1'b0;
  localparam logic REG_GYR_LIMIT = 1'b1;

  localparam logic [RAW_W-1:0] ACC_LIMIT_RST = 16'd16000;
  localparam logic [RAW_W-1:0] GYR_LIMIT_RST = 16'd5000;

  // Accel: round(a * 196133 / 640000) = (a * ACC_K + 2^34) >> 35.
  localparam int ACC_SH = 35;
  localparam int ACC_Q_W = 14;
  localparam int ACC_P_W = 50;
  localparam logic [63:0] ACC_K64 =
      ((64'd1 << ACC_SH) * 64'd196133 + 64'd639999) / 64'd640000;
  localparam logic [33:0] ACC_K = ACC_K64[33:0];
  localparam logic [ACC_P_W-1:0] ACC_HALF = ACC_P_W'(1) << (ACC_SH - 1);

  // Gyro: round(a * 128 / 131) = floor((a * 128 + 65) / 131).
  localparam int GYR_SH = 30;
  localparam int GYR_Q_W = 15;
  localparam int GYR_P_W = 46;
  localparam logic [63:0] GYR_K64 = ((64'd1 << GYR_SH) + 64'd130) / 64'd131;
  localparam logic [22:0] GYR_K = GYR_K64[22:0];
  localparam logic [6:0] GYR_LOW = 7'd65;

  // Temperature: round(m * 64 / 425) = floor(((m + 3) * 64 + 20) / 425).
  localparam int TMP_SH = 33;
  localparam int TMP_Q_W = 16;
  localparam int TMP_P_W = 49;
  localparam int TMP_N_W = 19;
  localparam int TMP_M_W = 18;
  localparam logic [63:0] TMP_K64 = ((64'd1 << TMP_SH) + 64'd424) / 64'd425;
  localparam logic [24:0] TMP_K = TMP_K64[24:0];
  localparam logic signed [TMP_N_W-1:0] TMP_OFS = 19'sd62101;
  localparam logic [TMP_M_W-1:0] TMP_HI = 18'd3;
  localparam logic [5:0] TMP_LOW = 6'd20;

endpackage

// ----- hdl/imu_spike_reject_and_scale_unit.sv -----
// ---------------------------------------------------------------------------
// IMU spike reject and scale unit
// Rejects per-axis jumps beyond a programmable limit and scales the chosen
// accel, gyro and temperature counts to fixed-point physical units.
// ---------------------------------------------------------------------------
//  Channel   Handshake                  Payload
//  in_       in_valid / in_stall        seven raw 16-bit counts
//  out_      out_valid / out_stall      three accel, three gyro, temperature
//  config    psel/penable/pwrite/pready two 16-bit spike limits
//
// One item per cycle while no stalled output backs up to the input.
// Each item passes the four pipeline registers: input, select, multiply, output.
// Reset restores both limits and the first-sample state; the held axes clear.
// A stalled output backs up through the pipeline; empty stages still fill.
// ---------------------------------------------------------------------------
module imu_spike_reject_and_scale_unit
  import imusr_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [RAW_W-1:0]   in_accel_x_raw,
  input  logic signed [RAW_W-1:0]   in_accel_y_raw,
  input  logic signed [RAW_W-1:0]   in_accel_z_raw,
  input  logic signed [RAW_W-1:0]   in_temp_raw,
  input  logic signed [RAW_W-1:0]   in_gyro_x_raw,
  input  logic signed [RAW_W-1:0]   in_gyro_y_raw,
  input  logic signed [RAW_W-1:0]   in_gyro_z_raw,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [ACC_W-1:0]   out_accel_x_ms2,
  output logic signed [ACC_W-1:0]   out_accel_y_ms2,
  output logic signed [ACC_W-1:0]   out_accel_z_ms2,
  output logic signed [GYR_W-1:0]   out_gyro_x_dps,
  output logic signed [GYR_W-1:0]   out_gyro_y_dps,
  output logic signed [GYR_W-1:0]   out_gyro_z_dps,
  output logic signed [TMP_W-1:0]   out_temp_celsius,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [PADDR_W-1:0]        paddr,
  input  logic [PDATA_W-1:0]        pwdata,
  output logic [PDATA_W-1:0]        prdata,
  output logic                      pready
);

`include "imu_spike_reject_and_scale_unit_assert.svh"

  logic [RAW_W-1:0] acc_lim_r;
  logic [RAW_W-1:0] gyr_lim_r;
  logic             cfg_wr;

  logic v1_r, v2_r, v3_r, v4_r;
  logic free1, free2, free3, free4;
  logic mv1;

  logic [AXES-1:0][RAW_W-1:0] s1_axis_r;
  logic [RAW_W-1:0]           s1_temp_r;

  logic [AXES-1:0][RAW_W-1:0] held_r;
  logic                       first_r;

  logic [AXES-1:0][RAW_W-1:0] chosen;
  logic [AXES-1:0]            keep_new;
  logic [AXES-1:0][RAW_W:0]   diff;
  logic [AXES-1:0][RAW_W:0]   jump;
  logic [AXES-1:0][RAW_W-1:0] mag;

  logic signed [TMP_N_W-1:0]  tmp_ext;
  logic signed [TMP_N_W-1:0]  tmp_num;
  logic [TMP_M_W-1:0]         tmp_mag;

  logic [AXES-1:0][RAW_W-1:0] s2_mag_r;
  logic [AXES-1:0]            s2_neg_r;
  logic [TMP_M_W-1:0]         s2_tmag_r;
  logic                       s2_tneg_r;

  logic [2:0][ACC_P_W-1:0]    aprod;
  logic [2:0][GYR_P_W-1:0]    gprod;
  logic [TMP_M_W-1:0]         tmp_hi;
  logic [TMP_P_W-1:0]         tprod;

  logic [2:0][ACC_Q_W-1:0]    s3_aq_r;
  logic [2:0][GYR_Q_W-1:0]    s3_gq_r;
  logic [TMP_Q_W-1:0]         s3_tq_r;
  logic [AXES-1:0]            s3_neg_r;
  logic                       s3_tneg_r;

  logic signed [ACC_W-1:0] out_ax_r, out_ay_r, out_az_r;
  logic signed [GYR_W-1:0] out_gx_r, out_gy_r, out_gz_r;
  logic signed [TMP_W-1:0] out_t_r;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_lim_r <= ACC_LIMIT_RST;
      gyr_lim_r <= GYR_LIMIT_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_ACC_LIMIT: acc_lim_r <= pwdata[RAW_W-1:0];
        REG_GYR_LIMIT: gyr_lim_r <= pwdata[RAW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_ACC_LIMIT: prdata = PDATA_W'(acc_lim_r);
      REG_GYR_LIMIT: prdata = PDATA_W'(gyr_lim_r);
      default:       prdata = '0;
    endcase
  end

  // Pipeline flow control.
  assign free4    = !v4_r || !out_stall;
  assign free3    = !v3_r || free4;
  assign free2    = !v2_r || free3;
  assign free1    = !v1_r || free2;
  assign mv1      = v1_r && free2;
  assign in_stall = !free1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (free1) begin
        v1_r <= in_valid;
      end
      if (free2) begin
        v2_r <= v1_r;
      end
      if (free3) begin
        v3_r <= v2_r;
      end
      if (free4) begin
        v4_r <= v3_r;
      end
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (free1 && in_valid) begin
      s1_axis_r[0] <= in_accel_x_raw;
      s1_axis_r[1] <= in_accel_y_raw;
      s1_axis_r[2] <= in_accel_z_raw;
      s1_axis_r[3] <= in_gyro_x_raw;
      s1_axis_r[4] <= in_gyro_y_raw;
      s1_axis_r[5] <= in_gyro_z_raw;
      s1_temp_r    <= in_temp_raw;
    end
  end

  // Spike rejection against the held values.
  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      diff[i] = {s1_axis_r[i][RAW_W-1], s1_axis_r[i]} - {held_r[i][RAW_W-1], held_r[i]};
      jump[i] = diff[i][RAW_W] ? (RAW_W+1)'(-diff[i]) : diff[i];
      if (i < 3) begin
        keep_new[i] = first_r || (jump[i] <= {1'b0, acc_lim_r});
      end else begin
        keep_new[i] = first_r || (jump[i] <= {1'b0, gyr_lim_r});
      end
      chosen[i] = keep_new[i] ? s1_axis_r[i] : held_r[i];
      mag[i]    = chosen[i][RAW_W-1] ? RAW_W'(-chosen[i]) : chosen[i];
    end
  end

  assign tmp_ext = TMP_N_W'(signed'(s1_temp_r));
  assign tmp_num = (tmp_ext <<< 2) + tmp_ext + TMP_OFS;
  assign tmp_mag = tmp_num[TMP_N_W-1] ? TMP_M_W'(-tmp_num) : tmp_num[TMP_M_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r  <= '0;
      first_r <= 1'b1;
    end else if (mv1) begin
      first_r <= 1'b0;
      for (int i = 0; i < AXES; i++) begin
        if (keep_new[i]) begin
          held_r[i] <= s1_axis_r[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mv1) begin
      for (int i = 0; i < AXES; i++) begin
        s2_mag_r[i] <= mag[i];
        s2_neg_r[i] <= chosen[i][RAW_W-1];
      end
      s2_tmag_r <= tmp_mag;
      s2_tneg_r <= tmp_num[TMP_N_W-1];
    end
  end

  // Constant scaling by reciprocal multiplication.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      aprod[i] = ACC_P_W'(s2_mag_r[i]) * ACC_P_W'(ACC_K) + ACC_HALF;
      gprod[i] = GYR_P_W'({s2_mag_r[i+3], GYR_LOW}) * GYR_P_W'(GYR_K);
    end
  end

  assign tmp_hi = s2_tmag_r + TMP_HI;
  assign tprod  = TMP_P_W'({tmp_hi, TMP_LOW}) * TMP_P_W'(TMP_K);

  always_ff @(posedge clk) begin
    if (v2_r && free3) begin
      for (int i = 0; i < 3; i++) begin
        s3_aq_r[i] <= aprod[i][ACC_SH +: ACC_Q_W];
        s3_gq_r[i] <= gprod[i][GYR_SH +: GYR_Q_W];
      end
      s3_tq_r   <= tprod[TMP_SH +: TMP_Q_W];
      s3_neg_r  <= s2_neg_r;
      s3_tneg_r <= s2_tneg_r;
    end
  end

  // Output register with sign restore.
  always_ff @(posedge clk) begin
    if (v3_r && free4) begin
      out_ax_r <= s3_neg_r[0] ? -ACC_W'(s3_aq_r[0]) : ACC_W'(s3_aq_r[0]);
      out_ay_r <= s3_neg_r[1] ? -ACC_W'(s3_aq_r[1]) : ACC_W'(s3_aq_r[1]);
      out_az_r <= s3_neg_r[2] ? -ACC_W'(s3_aq_r[2]) : ACC_W'(s3_aq_r[2]);
      out_gx_r <= s3_neg_r[3] ? -GYR_W'(s3_gq_r[0]) : GYR_W'(s3_gq_r[0]);
      out_gy_r <= s3_neg_r[4] ? -GYR_W'(s3_gq_r[1]) : GYR_W'(s3_gq_r[1]);
      out_gz_r <= s3_neg_r[5] ? -GYR_W'(s3_gq_r[2]) : GYR_W'(s3_gq_r[2]);
      out_t_r  <= s3_tneg_r ? -TMP_W'(s3_tq_r) : TMP_W'(s3_tq_r);
    end
  end

  assign out_valid        = v4_r;
  assign out_accel_x_ms2  = out_ax_r;
  assign out_accel_y_ms2  = out_ay_r;
  assign out_accel_z_ms2  = out_az_r;
  assign out_gyro_x_dps   = out_gx_r;
  assign out_gyro_y_dps   = out_gy_r;
  assign out_gyro_z_dps   = out_gz_r;
  assign out_temp_celsius = out_t_r;

  `IMUSR_ASSERT(a_stall_needs_item, in_stall |-> v1_r, "input stalled with empty input stage")
  `IMUSR_ASSERT(a_first_clears, mv1 |=> !first_r, "first-sample flag still set after an item")
  `IMUSR_ASSERT(a_held_stable, !mv1 |=> $stable(held_r), "held axes changed without an item")
  `IMUSR_ASSERT(a_acc_limit_write, (cfg_wr && (paddr[2] == REG_ACC_LIMIT)) |=> (acc_lim_r == $past(pwdata[RAW_W-1:0])), "accel limit write lost")
  `IMUSR_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "result valid right after reset")

endmodule

// ----- tb/imu_spike_reject_and_scale_unit_tb.sv -----
// ---------------------------------------------------------------------------
// IMU spike reject and scale unit: self-checking testbench
// Sends raw inertial sample sets through the valid/stall input channel and
// programs both spike limits over the APB port between runs of items. A
// predictor with its own held-axis state computes the scaled reading for each
// accepted item, and the monitor compares every field of each output item
// against the oldest prediction. Both channels idle in random bursts, and the
// receiver once holds off long enough for the input to back up.
// ---------------------------------------------------------------------------
module imu_spike_reject_and_scale_unit_tb;
  import imusr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PRESSURE_AT = 100;
  localparam int LONG_HOLD   = 300;
  localparam int PHASE_ITEMS = 310;

  typedef struct packed {
    logic [AXES-1:0][RAW_W-1:0] axis;
    logic [RAW_W-1:0]           temp;
  } raw_sample_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] accel_x;
    logic signed [ACC_W-1:0] accel_y;
    logic signed [ACC_W-1:0] accel_z;
    logic signed [GYR_W-1:0] gyro_x;
    logic signed [GYR_W-1:0] gyro_y;
    logic signed [GYR_W-1:0] gyro_z;
    logic signed [TMP_W-1:0] temp;
  } reading_t;

  typedef struct packed {
    logic [AXES-1:0][RAW_W-1:0] held;
    logic                       first;
    logic [RAW_W-1:0]           acc_limit;
    logic [RAW_W-1:0]           gyr_limit;
  } axis_filter_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic signed [RAW_W-1:0] in_accel_x_raw = '0;
  logic signed [RAW_W-1:0] in_accel_y_raw = '0;
  logic signed [RAW_W-1:0] in_accel_z_raw = '0;
  logic signed [RAW_W-1:0] in_temp_raw = '0;
  logic signed [RAW_W-1:0] in_gyro_x_raw = '0;
  logic signed [RAW_W-1:0] in_gyro_y_raw = '0;
  logic signed [RAW_W-1:0] in_gyro_z_raw = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [ACC_W-1:0] out_accel_x_ms2;
  logic signed [ACC_W-1:0] out_accel_y_ms2;
  logic signed [ACC_W-1:0] out_accel_z_ms2;
  logic signed [GYR_W-1:0] out_gyro_x_dps;
  logic signed [GYR_W-1:0] out_gyro_y_dps;
  logic signed [GYR_W-1:0] out_gyro_z_dps;
  logic signed [TMP_W-1:0] out_temp_celsius;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [PADDR_W-1:0]      paddr = '0;
  logic [PDATA_W-1:0]      pwdata = '0;
  logic [PDATA_W-1:0]      prdata;
  logic                    pready;

  raw_sample_t  pending_samples[$];
  reading_t     predicted_readings[$];
  axis_filter_t gen_model;
  axis_filter_t chk_model;
  raw_sample_t  next_sample;
  raw_sample_t  port_sample;
  reading_t     due;
  logic         in_taken = 1'b0;
  logic         idling_on = 1'b1;
  logic         pressure_done = 1'b0;
  int           send_gap = 0;
  int           stall_left = 0;
  int           samples_taken = 0;
  int           failures = 0;

  imu_spike_reject_and_scale_unit u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_accel_x_raw   (in_accel_x_raw),
    .in_accel_y_raw   (in_accel_y_raw),
    .in_accel_z_raw   (in_accel_z_raw),
    .in_temp_raw      (in_temp_raw),
    .in_gyro_x_raw    (in_gyro_x_raw),
    .in_gyro_y_raw    (in_gyro_y_raw),
    .in_gyro_z_raw    (in_gyro_z_raw),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_accel_x_ms2  (out_accel_x_ms2),
    .out_accel_y_ms2  (out_accel_y_ms2),
    .out_accel_z_ms2  (out_accel_z_ms2),
    .out_gyro_x_dps   (out_gyro_x_dps),
    .out_gyro_y_dps   (out_gyro_y_dps),
    .out_gyro_z_dps   (out_gyro_z_dps),
    .out_temp_celsius (out_temp_celsius),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always #5 clk = ~clk;

  function automatic axis_filter_t state_after_reset();
    axis_filter_t st;
    st.held      = '0;
    st.first     = 1'b1;
    st.acc_limit = ACC_LIMIT_RST;
    st.gyr_limit = GYR_LIMIT_RST;
    return st;
  endfunction

  // Round to nearest with ties away from zero; den is positive.
  function automatic longint round_nearest(input longint num, input longint den);
    if (num >= 0) return (num + den / 2) / den;
    return -((-num + den / 2) / den);
  endfunction

  function automatic reading_t reject_and_scale(inout axis_filter_t st, input raw_sample_t s);
    int       raw;
    int       held;
    int       jump;
    int       lim;
    int       chosen [AXES];
    reading_t r;
    for (int i = 0; i < AXES; i++) begin
      raw  = $signed(s.axis[i]);
      held = $signed(st.held[i]);
      jump = raw - held;
      if (jump < 0) jump = -jump;
      lim = (i < 3) ? int'(st.acc_limit) : int'(st.gyr_limit);
      if (!st.first && jump > lim) begin
        chosen[i] = held;
      end else begin
        st.held[i] = s.axis[i];
        chosen[i]  = raw;
      end
    end
    st.first = 1'b0;
    r.accel_x = ACC_W'(round_nearest(longint'(chosen[0]) * 980665, 3200000));
    r.accel_y = ACC_W'(round_nearest(longint'(chosen[1]) * 980665, 3200000));
    r.accel_z = ACC_W'(round_nearest(longint'(chosen[2]) * 980665, 3200000));
    r.gyro_x  = GYR_W'(round_nearest(longint'(chosen[3]) * 128, 131));
    r.gyro_y  = GYR_W'(round_nearest(longint'(chosen[4]) * 128, 131));
    r.gyro_z  = GYR_W'(round_nearest(longint'(chosen[5]) * 128, 131));
    r.temp    = TMP_W'(round_nearest((longint'($signed(s.temp)) * 5 + 62101) * 64, 425));
    return r;
  endfunction

  function automatic logic [RAW_W-1:0] clamp_raw(input int v);
    if (v > 32767) return 16'h7FFF;
    if (v < -32768) return 16'h8000;
    return RAW_W'(v);
  endfunction

  function automatic raw_sample_t make_sample(input int ax, input int ay, input int az,
                                              input int t, input int gx, input int gy,
                                              input int gz);
    raw_sample_t s;
    s.axis = {RAW_W'(gz), RAW_W'(gy), RAW_W'(gx), RAW_W'(az), RAW_W'(ay), RAW_W'(ax)};
    s.temp = RAW_W'(t);
    return s;
  endfunction

  function automatic raw_sample_t step_from_held(input int delta);
    raw_sample_t s;
    for (int i = 0; i < AXES; i++) s.axis[i] = clamp_raw($signed(gen_model.held[i]) + delta);
    s.temp = RAW_W'($urandom);
    return s;
  endfunction

  // Mostly smooth motion within the limit, some jumps right at and just past
  // the limit, and some samples with no relation to the held value.
  function automatic logic [RAW_W-1:0] next_axis(input logic [RAW_W-1:0] held,
                                                 input logic [RAW_W-1:0] limit);
    int base;
    int lim;
    int pick;
    base = $signed(held);
    lim  = limit;
    pick = $urandom_range(0, 99);
    if (pick < 60) return clamp_raw(base + int'($urandom_range(0, 2 * lim)) - lim);
    if (pick < 70) return clamp_raw($urandom_range(0, 1) ? base + lim : base - lim);
    if (pick < 80) return clamp_raw($urandom_range(0, 1) ? base + lim + 1 : base - lim - 1);
    return RAW_W'($urandom);
  endfunction

  task automatic queue_sample(input raw_sample_t s);
    void'(reject_and_scale(gen_model, s));
    pending_samples.push_back(s);
  endtask

  task automatic wait_idle();
    while (pending_samples.size() != 0 || in_valid || predicted_readings.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_limit(input logic idx, input logic [RAW_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({idx, 2'b00});
    pwdata  <= PDATA_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic program_limits(input logic [RAW_W-1:0] acc, input logic [RAW_W-1:0] gyr);
    write_limit(REG_ACC_LIMIT, acc);
    write_limit(REG_GYR_LIMIT, gyr);
    gen_model.acc_limit = acc;
    gen_model.gyr_limit = gyr;
  endtask

  task automatic run_random_phase(input int count);
    raw_sample_t s;
    for (int n = 0; n < count; n++) begin
      for (int i = 0; i < AXES; i++)
        s.axis[i] = next_axis(gen_model.held[i],
                              (i < 3) ? gen_model.acc_limit : gen_model.gyr_limit);
      s.temp = RAW_W'($urandom);
      queue_sample(s);
    end
    wait_idle();
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endtask

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_samples.size() > 0) begin
        next_sample = pending_samples.pop_front();
        in_accel_x_raw <= next_sample.axis[0];
        in_accel_y_raw <= next_sample.axis[1];
        in_accel_z_raw <= next_sample.axis[2];
        in_gyro_x_raw  <= next_sample.axis[3];
        in_gyro_y_raw  <= next_sample.axis[4];
        in_gyro_z_raw  <= next_sample.axis[5];
        in_temp_raw    <= next_sample.temp;
        in_valid       <= 1'b1;
        if (idling_on && $urandom_range(0, 3) == 0) send_gap <= $urandom_range(1, 19);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (!pressure_done && samples_taken >= PRESSURE_AT) begin
      out_stall     <= 1'b1;
      stall_left    <= LONG_HOLD;
      pressure_done <= 1'b1;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (idling_on && $urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 18);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && !in_stall;
      if (psel && penable && pwrite && pready) begin
        if (paddr[PADDR_W-1:2] == REG_ACC_LIMIT) chk_model.acc_limit = pwdata[RAW_W-1:0];
        else if (paddr[PADDR_W-1:2] == REG_GYR_LIMIT) chk_model.gyr_limit = pwdata[RAW_W-1:0];
      end
      if (in_valid && !in_stall) begin
        port_sample.axis = {in_gyro_z_raw, in_gyro_y_raw, in_gyro_x_raw,
                            in_accel_z_raw, in_accel_y_raw, in_accel_x_raw};
        port_sample.temp = in_temp_raw;
        predicted_readings.push_back(reject_and_scale(chk_model, port_sample));
        samples_taken <= samples_taken + 1;
      end
      if (out_valid && !out_stall) begin
        if (predicted_readings.size() == 0) begin
          $error("output item with no prediction waiting");
          failures++;
        end else begin
          due = predicted_readings.pop_front();
          check_field("accel_x_ms2", $signed(due.accel_x), out_accel_x_ms2);
          check_field("accel_y_ms2", $signed(due.accel_y), out_accel_y_ms2);
          check_field("accel_z_ms2", $signed(due.accel_z), out_accel_z_ms2);
          check_field("gyro_x_dps", $signed(due.gyro_x), out_gyro_x_dps);
          check_field("gyro_y_dps", $signed(due.gyro_y), out_gyro_y_dps);
          check_field("gyro_z_dps", $signed(due.gyro_z), out_gyro_z_dps);
          check_field("temp_celsius", $signed(due.temp), out_temp_celsius);
        end
      end
    end
  end

  initial begin
    gen_model = state_after_reset();
    chk_model = state_after_reset();
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // The first item is taken whatever it holds; then jumps of exactly the
    // limit pass and one count more is rejected.
    queue_sample(make_sample(-32768, -32768, -32768, -32768, -32768, -32768, -32768));
    queue_sample(make_sample(-16768, -16768, -16768, 32767, -27768, -27768, -27768));
    queue_sample(make_sample(-767, -767, -767, 0, -22767, -22767, -22767));
    queue_sample(make_sample(32767, -16768, -32768, -1, -32768, 32767, -27768));
    wait_idle();

    // With a zero limit only an unchanged value gets through.
    program_limits(16'd0, 16'd0);
    queue_sample(step_from_held(0));
    queue_sample(step_from_held(1));
    queue_sample(step_from_held(-1));
    queue_sample(step_from_held(0));
    wait_idle();

    program_limits(16'hFFFF, 16'hFFFF);
    queue_sample(make_sample(32767, 32767, 32767, 12345, 32767, 32767, 32767));
    queue_sample(make_sample(-32768, -32768, -32768, -12345, -32768, -32768, -32768));
    queue_sample(make_sample(0, 0, 0, 0, 0, 0, 0));
    queue_sample(make_sample(1, -1, 2, 100, -2, 3, -3));
    wait_idle();

    program_limits(16'd1000, 16'd300);
    run_random_phase(PHASE_ITEMS);
    program_limits(16'd0, 16'd0);
    run_random_phase(PHASE_ITEMS);
    program_limits(16'hFFFF, 16'hFFFF);
    run_random_phase(PHASE_ITEMS);
    program_limits(RAW_W'($urandom), RAW_W'($urandom));
    run_random_phase(PHASE_ITEMS);
    program_limits(ACC_LIMIT_RST, GYR_LIMIT_RST);
    run_random_phase(PHASE_ITEMS);
    idling_on = 1'b0;
    program_limits(RAW_W'($urandom_range(1, 64)), RAW_W'($urandom_range(1, 64)));
    run_random_phase(PHASE_ITEMS);

    if (failures == 0) begin
      $display("** imu_spike_reject_and_scale_unit: PASSED **");
    end else begin
      $display("** imu_spike_reject_and_scale_unit: FAILED **");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("** imu_spike_reject_and_scale_unit: FAILED **");
    $finish;
  end

endmodule
